// File: design/scp_pkg.sv
package scp_pkg;

	localparam int MAX_POINTS = 32;
	localparam int PT_AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int LOG_BITS   = 40;
	localparam int SQ_STEPS   = 16;
	localparam int IT_W       = 6;

	localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AB;
	localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;
	localparam logic [16:0] PROB_ONE = 17'd65536;
	localparam logic [23:0] N_LIMIT  = 24'd18;

	typedef logic signed [15:0] sinr_t;
	typedef logic [16:0]        prob_t;
	typedef logic [15:0]        len_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_ORDER = 3'd2,
		ST_FULL  = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		sinr_t sinr;
		prob_t prob;
	} point_t;

	typedef struct packed {
		logic        go;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic        go;
		logic [63:0] num;
		len_t        den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

// File: design/scp_if.sv
interface scp_req_if;
	logic              valid;
	logic              ready;
	scp_pkg::opcode_t  opcode;
	scp_pkg::sinr_t    sinr;
	scp_pkg::prob_t    point_probability;
	scp_pkg::len_t     packet_length;

	modport source (output valid, opcode, sinr, point_probability, packet_length, input ready);
	modport sink (input valid, opcode, sinr, point_probability, packet_length, output ready);
endinterface

interface scp_rsp_if;
	logic              valid;
	logic              ready;
	scp_pkg::prob_t    probability;
	scp_pkg::status_t  status;

	modport source (output valid, probability, status, input ready);
	modport sink (input valid, probability, status, output ready);
endinterface

// File: design/sinr_curve_reception_probability_core.sv
// sinr curve reception probability core
// req channel: one beat per command (clear table, append point, query).
// rsp channel: exactly one beat per command, probability in q16 plus status.
// cfg_wr_en/cfg_wr_data load the reference packet length; write it only while
// the core is idle. zero turns the length scaling off.
// the curve table sits in a synchronous ram with one write and one registered
// read port, scanned one entry at a time (address state, compare state).
// a clear resets the point count only; an append scans the stored points
// before it writes; a query above the last point reads the last entry only,
// below the first point also the first entry; an interpolated query scans to
// its segment, then runs one product and one 64-step divide. length scaling
// adds 40 squarings for the log, three products and one 64-step divide for the
// exponent, 16 squarings for the power, all on a shared multiplier.
// one command is worked at a time; the next is taken once the result sits in
// the output register, so a stalled receiver holds one result and lets the
// following command run, then blocks before it is returned.
// reset empties the table and clears the reference length; table contents
// are not cleared, there is no sweep after reset.
module sinr_curve_reception_probability_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  scp_pkg::len_t          cfg_wr_data,
	scp_req_if.sink                req,
	scp_rsp_if.source              rsp
);
	import scp_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE = 15'h0001,
		S_RD   = 15'h0002,
		S_CHK  = 15'h0004,
		S_WR   = 15'h0008,
		S_IMUL = 15'h0010,
		S_IDIV = 15'h0020,
		S_PW   = 15'h0040,
		S_LOG  = 15'h0080,
		S_ZMUL = 15'h0100,
		S_ZDIV = 15'h0200,
		S_WMUL = 15'h0400,
		S_UMUL = 15'h0800,
		S_SQ   = 15'h1000,
		S_RND  = 15'h2000,
		S_DONE = 15'h4000
	} state_t;

	state_t state_q;

	point_t mem [MAX_POINTS];
	point_t rd_q;

	opcode_t op_q;
	sinr_t   s_q;
	prob_t   pp_q;
	len_t    len_q, ref_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PT_AW-1:0] idx_q;
	logic             last_phase_q;
	logic signed [16:0] t_q;
	sinr_t   xp_q;
	prob_t   yp_q;
	logic [15:0] dx_q;
	logic        up_q;
	prob_t   prob_q, res_prob_q;
	status_t res_st_q;
	logic [3:0]  k_q;
	logic [LOG_BITS-1:0] frac_q;
	logic [IT_W-1:0] it_q;
	logic [4:0]  n_q;
	logic [63:0] v_q;
	logic [63:0] rd_u_q;

	logic     rsp_valid_q;
	prob_t    rsp_prob_q;
	status_t  rsp_st_q;

	mul_req_t mul_req_q;
	mul_rsp_t mul_rsp;
	div_req_t div_req_q;
	div_rsp_t div_rsp;

	scp_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req_q), .rsp(mul_rsp));
	scp_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .rsp(div_rsp));

	function automatic logic [3:0] msb16(input logic [15:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) r = 4'(i);
		end
		return r;
	endfunction

	logic [CNT_W-1:0] cnt_m1;
	logic signed [16:0] e_sx, xp_sx, s_sx;
	logic [16:0] dx_w, off_w;
	logic        up_w;
	prob_t       d_w;
	logic [3:0]  k_w;
	logic [63:0] xnorm, sq, xn, logv, u_w, v0, rsum, rsh;
	logic [6:0]  shamt;
	logic        lbit;
	logic [LOG_BITS-1:0] frac_n;
	logic [16:0] q_w;
	logic        mul_go, div_go, rsp_load;

	always_comb begin
		cnt_m1 = cnt_q - CNT_W'(1);
		e_sx   = {rd_q.sinr[15], rd_q.sinr};
		xp_sx  = {xp_q[15], xp_q};
		s_sx   = {s_q[15], s_q};
		dx_w   = 17'(e_sx - xp_sx);
		off_w  = 17'(t_q - xp_sx);
		up_w   = (rd_q.prob >= yp_q);
		d_w    = up_w ? (rd_q.prob - yp_q) : (yp_q - rd_q.prob);
		k_w    = msb16(prob_q[15:0]);
		xnorm  = {48'd0, prob_q[15:0]} << (6'd62 - {2'd0, k_w});
		// q62 square, keep top bit below two
		sq     = mul_rsp.prod[125:62];
		lbit   = sq[63];
		xn     = lbit ? (sq >> 1) : sq;
		frac_n = {frac_q[LOG_BITS-2:0], lbit};
		logv   = ({59'd0, 5'd16 - {1'b0, k_q}} << LOG_BITS) - {24'd0, frac_n};
		// e^-u with u = w / 2^16, then squared 16 times
		u_w    = {18'd0, mul_rsp.prod[127:82]};
		v0     = Q62_ONE - rd_u_q + {1'b0, sq[63:1]};
		q_w    = div_rsp.quo[16:0];
		shamt  = 7'd46 + {2'd0, n_q};
		rsum   = v_q + (64'd1 << (shamt - 7'd1));
		rsh    = rsum >> shamt;
	end

	// start pulses for the shared multiplier and divider
	always_comb begin
		mul_go   = 1'b0;
		div_go   = 1'b0;
		rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
		case (state_q)
			S_CHK:  mul_go = (op_q != OP_APPEND) && !last_phase_q && (idx_q != '0)
				&& (t_q < e_sx);
			S_PW:   mul_go = (ref_q != '0) && (len_q != '0) && (prob_q < PROB_ONE)
				&& (prob_q != '0);
			S_LOG:  mul_go = mul_rsp.done;
			S_WMUL: mul_go = mul_rsp.done;
			S_UMUL: mul_go = mul_rsp.done;
			S_ZDIV: mul_go = div_rsp.done && (div_rsp.quo[63:LOG_BITS] < N_LIMIT);
			S_SQ:   mul_go = mul_rsp.done && (it_q != IT_W'(SQ_STEPS - 1));
			S_IMUL: div_go = mul_rsp.done;
			S_ZMUL: div_go = mul_rsp.done;
			default: ;
		endcase
	end

	// table ram: one write and one registered read port
	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			mem[cnt_q[PT_AW-1:0]] <= '{sinr: s_q, prob: (pp_q > PROB_ONE) ? PROB_ONE : pp_q};
		end
		if (state_q == S_RD) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_NOP;
			s_q          <= '0;
			pp_q         <= '0;
			len_q        <= '0;
			ref_q        <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			last_phase_q <= 1'b0;
			t_q          <= '0;
			xp_q         <= '0;
			yp_q         <= '0;
			dx_q         <= '0;
			up_q         <= 1'b0;
			prob_q       <= '0;
			res_prob_q   <= '0;
			res_st_q     <= ST_OK;
			k_q          <= '0;
			frac_q       <= '0;
			it_q         <= '0;
			n_q          <= '0;
			v_q          <= '0;
			rd_u_q       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_prob_q   <= '0;
			rsp_st_q     <= ST_OK;
			mul_req_q    <= '0;
			div_req_q    <= '0;
		end else begin
			mul_req_q.go <= mul_go;
			div_req_q.go <= div_go;
			if (cfg_wr_en) begin
				ref_q <= cfg_wr_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q       <= req.opcode;
						s_q        <= req.sinr;
						pp_q       <= req.point_probability;
						len_q      <= req.packet_length;
						res_prob_q <= '0;
						res_st_q   <= ST_OK;
						case (req.opcode)
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
							OP_APPEND: begin
								idx_q        <= '0;
								last_phase_q <= 1'b0;
								state_q      <= (cnt_q == '0) ? S_WR : S_RD;
							end
							OP_QUERY: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									idx_q        <= cnt_m1[PT_AW-1:0];
									last_phase_q <= 1'b1;
									state_q      <= S_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end

				S_RD: state_q <= S_CHK;

				S_CHK: begin
					if (op_q == OP_APPEND) begin
						if (s_q == rd_q.sinr) begin
							res_st_q <= ST_DUP;
							state_q  <= S_DONE;
						end else if (s_q < $signed(rd_q.sinr)) begin
							res_st_q <= ST_ORDER;
							state_q  <= S_DONE;
						end else if (CNT_W'(idx_q) == cnt_m1) begin
							if (cnt_q >= CNT_W'(MAX_POINTS)) begin
								res_st_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_WR;
							end
						end else begin
							idx_q   <= idx_q + PT_AW'(1);
							state_q <= S_RD;
						end
					end else if (last_phase_q) begin
						if (s_q > $signed(rd_q.sinr)) begin
							res_prob_q <= PROB_ONE;
							state_q    <= S_DONE;
						end else begin
							t_q          <= (s_q == rd_q.sinr) ? (s_sx - 17'sd1) : s_sx;
							last_phase_q <= 1'b0;
							idx_q        <= '0;
							state_q      <= S_RD;
						end
					end else if (idx_q == '0) begin
						if (s_q < $signed(rd_q.sinr)) begin
							state_q <= S_DONE;
						end else if (cnt_q == CNT_W'(1)) begin
							prob_q  <= rd_q.prob;
							state_q <= S_PW;
						end else begin
							xp_q    <= rd_q.sinr;
							yp_q    <= rd_q.prob;
							idx_q   <= PT_AW'(1);
							state_q <= S_RD;
						end
					end else if (t_q < e_sx) begin
						// segment found: off * |dy| on the multiplier
						dx_q        <= dx_w[15:0];
						up_q        <= up_w;
						mul_req_q.a <= {48'd0, off_w[15:0]};
						mul_req_q.b <= {47'd0, d_w};
						state_q     <= S_IMUL;
					end else begin
						xp_q    <= rd_q.sinr;
						yp_q    <= rd_q.prob;
						idx_q   <= idx_q + PT_AW'(1);
						state_q <= S_RD;
					end
				end

				S_WR: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end

				S_IMUL: begin
					if (mul_rsp.done) begin
						div_req_q.num <= mul_rsp.prod[63:0] + {49'd0, dx_q[15:1]};
						div_req_q.den <= dx_q;
						state_q       <= S_IDIV;
					end
				end

				S_IDIV: begin
					if (div_rsp.done) begin
						prob_q  <= up_q ? (yp_q + q_w) : (yp_q - q_w);
						state_q <= S_PW;
					end
				end

				S_PW: begin
					if (ref_q == '0) begin
						res_prob_q <= prob_q;
						state_q    <= S_DONE;
					end else if (len_q == '0 || prob_q >= PROB_ONE) begin
						res_prob_q <= PROB_ONE;
						state_q    <= S_DONE;
					end else if (prob_q == '0) begin
						state_q <= S_DONE;
					end else begin
						k_q          <= k_w;
						frac_q       <= '0;
						it_q         <= '0;
						mul_req_q.a  <= xnorm;
						mul_req_q.b  <= xnorm;
						state_q      <= S_LOG;
					end
				end

				S_LOG: begin
					if (mul_rsp.done) begin
						frac_q <= frac_n;
						it_q   <= it_q + IT_W'(1);
						if (it_q == IT_W'(LOG_BITS - 1)) begin
							mul_req_q.a <= logv;
							mul_req_q.b <= {48'd0, len_q};
							state_q     <= S_ZMUL;
						end else begin
							mul_req_q.a <= xn;
							mul_req_q.b <= xn;
						end
					end
				end

				S_ZMUL: begin
					if (mul_rsp.done) begin
						div_req_q.num <= mul_rsp.prod[63:0];
						div_req_q.den <= ref_q;
						state_q       <= S_ZDIV;
					end
				end

				S_ZDIV: begin
					if (div_rsp.done) begin
						if (div_rsp.quo[63:LOG_BITS] >= N_LIMIT) begin
							state_q <= S_DONE;
						end else begin
							n_q          <= div_rsp.quo[LOG_BITS+4:LOG_BITS];
							mul_req_q.a  <= {div_rsp.quo[LOG_BITS-1:0], 24'd0};
							mul_req_q.b  <= LN2_Q64;
							state_q      <= S_WMUL;
						end
					end
				end

				S_WMUL: begin
					if (mul_rsp.done) begin
						rd_u_q       <= u_w;
						mul_req_q.a  <= u_w;
						mul_req_q.b  <= u_w;
						state_q      <= S_UMUL;
					end
				end

				S_UMUL: begin
					if (mul_rsp.done) begin
						it_q         <= '0;
						mul_req_q.a  <= v0;
						mul_req_q.b  <= v0;
						state_q      <= S_SQ;
					end
				end

				S_SQ: begin
					if (mul_rsp.done) begin
						it_q <= it_q + IT_W'(1);
						if (it_q == IT_W'(SQ_STEPS - 1)) begin
							v_q     <= sq;
							state_q <= S_RND;
						end else begin
							mul_req_q.a  <= sq;
							mul_req_q.b  <= sq;
						end
					end
				end

				S_RND: begin
					res_prob_q <= (rsh > {47'd0, PROB_ONE}) ? PROB_ONE : rsh[16:0];
					state_q    <= S_DONE;
				end

				S_DONE: begin
					if (rsp_load) begin
						rsp_prob_q  <= res_prob_q;
						rsp_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.probability = rsp_prob_q;
	assign rsp.status      = rsp_st_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count above table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q == '0))
		else $error("point count moved by more than one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("command accepted but core stayed idle");

endmodule

// File: design/scp_mul.sv
module scp_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  scp_pkg::mul_req_t req,
	output scp_pkg::mul_rsp_t rsp
);
	import scp_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sel_s1;
	logic         pv_s1;
	logic [127:0] acc_q;
	logic [31:0]  op_a, op_b;
	logic [127:0] pp_ext;

	// partial order: a0*b0, a0*b1, a1*b0, a1*b1
	always_comb begin
		op_a = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		op_b = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	end

	always_comb begin
		case (sel_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_ext = {32'd0, pp_s1, 32'd0};
			2'd3:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pp_s1  <= '0;
			sel_s1 <= '0;
			pv_s1  <= 1'b0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			if (pv_s1) begin
				acc_q <= acc_q + pp_ext;
			end
			if (req.go && !busy_q) begin
				a_q    <= req.a;
				b_q    <= req.b;
				cnt_q  <= '0;
				busy_q <= 1'b1;
				acc_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					pp_s1  <= op_a * op_b;
					sel_s1 <= cnt_q[1:0];
					pv_s1  <= 1'b1;
					cnt_q  <= cnt_q + 3'd1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// File: design/scp_div.sv
module scp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  scp_pkg::div_req_t req,
	output scp_pkg::div_rsp_t rsp
);
	import scp_pkg::*;

	logic [15:0] rem_q;
	logic [63:0] quo_q;
	len_t        den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [16:0] trial, diff;
	logic        ge;

	// one quotient bit a cycle, restoring
	always_comb begin
		trial = {rem_q, quo_q[63]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[15:0] : trial[15:0];
				quo_q <= {quo_q[62:0], ge};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// File: verif/sinr_curve_reception_probability_core_tb.sv
`timescale 1ns / 100ps

import scp_pkg::*;

typedef struct {
	int      prob;
	status_t status;
	bit      approx;
} rx_prob_t;

class curve_scoreboard;
	int       xs[MAX_POINTS];
	int       ys[MAX_POINTS];
	int       count;
	int       ref_len;
	rx_prob_t pending[$];
	int       errors;

	function new();
		count = 0;
		ref_len = 0;
		errors = 0;
	endfunction

	function int interpolate(int s);
		int t;
		longint dx, off, d, q;
		t = s;
		if (t == xs[count - 1])
			t--;
		for (int i = 0; i + 1 < count; i++) begin
			if (t >= xs[i] && t < xs[i + 1]) begin
				dx = xs[i + 1] - xs[i];
				off = t - xs[i];
				d = (ys[i + 1] >= ys[i]) ? ys[i + 1] - ys[i] : ys[i] - ys[i + 1];
				q = (off * d + dx / 2) / dx;
				return (ys[i + 1] >= ys[i]) ? ys[i] + int'(q) : ys[i] - int'(q);
			end
		end
		return 0;
	endfunction

	function void note_command(opcode_t op, sinr_t s_in, prob_t pp, len_t len);
		rx_prob_t e;
		int s;
		real r;
		s = s_in;
		e.prob = 0;
		e.status = ST_OK;
		e.approx = 0;
		case (op)
			OP_CLEAR: count = 0;
			OP_APPEND: begin
				for (int i = 0; i < count && e.status == ST_OK; i++) begin
					if (s == xs[i])
						e.status = ST_DUP;
					else if (s < xs[i])
						e.status = ST_ORDER;
				end
				if (e.status == ST_OK && count >= MAX_POINTS)
					e.status = ST_FULL;
				if (e.status == ST_OK) begin
					xs[count] = s;
					ys[count] = (pp > PROB_ONE) ? 65536 : int'(pp);
					count++;
				end
			end
			OP_QUERY: begin
				if (count == 0)
					e.status = ST_EMPTY;
				else if (s < xs[0])
					e.prob = 0;
				else if (s > xs[count - 1])
					e.prob = 65536;
				else begin
					e.prob = (count == 1) ? ys[0] : interpolate(s);
					if (ref_len > 0) begin
						if (len == 0)
							e.prob = 65536;
						else if (e.prob != 0 && e.prob != 65536) begin
							r = $pow(e.prob / 65536.0, real'(len) / real'(ref_len)) * 65536.0;
							e.prob = int'($floor(r + 0.5));
							e.approx = 1;
						end
					end
				end
			end
			default: ;
		endcase
		pending.insert(pending.size(), e);
	endfunction

	function void check_result(prob_t p, status_t st);
		rx_prob_t e;
		int diff;
		if (pending.size() == 0) begin
			$error("unexpected result beat: probability %0d status %0d", p, st);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (st !== e.status) begin
			$error("status: expected %0d, actual %0d", e.status, st);
			errors++;
		end
		diff = int'(p) - e.prob;
		if ($isunknown(p) || (e.approx ? (diff > 2 || diff < -2) : diff != 0)) begin
			$error("probability: expected %0d, actual %0d", e.prob, p);
			errors++;
		end
	endfunction
endclass

module sinr_curve_reception_probability_core_tb;
	logic  clk;
	logic  arst_n;
	logic  cfg_wr_en;
	len_t  cfg_wr_data;
	bit    idle_en;
	int    stall_cycles;
	bit    timed_out;

	curve_scoreboard sb;

	scp_req_if req ();
	scp_rsp_if rsp ();

	sinr_curve_reception_probability_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req.sink),
		.rsp         (rsp.source)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		rsp.ready <= idle_en ? ($urandom_range(99) >= 12) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_command(req.opcode, req.sinr, req.point_probability, req.packet_length);
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.probability, rsp.status);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 20000 && !timed_out) begin
			timed_out = 1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send(opcode_t op, int s, int pp, int len);
		if (idle_en && $urandom_range(99) < 12) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req.valid = 1'b1;
		req.opcode = op;
		req.sinr = sinr_t'(s);
		req.point_probability = prob_t'(pp);
		req.packet_length = len_t'(len);
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic write_ref_len(int v);
		req.valid = 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = len_t'(v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.ref_len = v;
	endtask

	function automatic int rand_len();
		case ($urandom_range(5))
			0: return 0;
			1: return 65535;
			2: return sb.ref_len;
			3: return $urandom_range(1, 8);
			default: return $urandom_range(65535);
		endcase
	endfunction

	task automatic run_phase(int n_queries);
		int n, x, s;
		send(OP_CLEAR, $urandom, $urandom, $urandom);
		n = ($urandom_range(9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 8);
		x = $urandom_range(0, 25500) - 25500;
		for (int i = 0; i < n; i++) begin
			// occasional extra append at or just below the next point: may repeat or step back
			if ($urandom_range(15) == 0)
				send(OP_APPEND, x - $urandom_range(0, 50), $urandom_range(65536), $urandom);
			send(OP_APPEND, x, ($urandom_range(19) == 0) ? $urandom_range(65537, 131071)
				: $urandom_range(65536), $urandom);
			x += $urandom_range(1, 3000);
			if (x > 32767)
				x = 32767;
		end
		for (int i = 0; i < n_queries; i++) begin
			case ($urandom_range(9))
				0: s = $urandom_range(65535) - 32768;
				1: s = (sb.count > 0) ? sb.xs[$urandom_range(sb.count - 1)] : 0;
				2: s = (sb.count > 0) ? sb.xs[sb.count - 1] : 0;
				3: begin
					send(opcode_t'($urandom_range(3)), $urandom, $urandom, $urandom);
					continue;
				end
				default: s = (sb.count > 0) ? $urandom_range(sb.xs[sb.count - 1] - sb.xs[0] + 400)
					+ sb.xs[0] - 200 : 0;
			endcase
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			send(OP_QUERY, s, $urandom, rand_len());
		end
	endtask

	initial begin
		int refs[5];
		sb = new();
		req.valid = 1'b0;
		req.opcode = OP_CLEAR;
		req.sinr = '0;
		req.point_probability = '0;
		req.packet_length = '0;
		rsp.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		idle_en = 1;
		stall_cycles = 0;
		timed_out = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		send(OP_QUERY, 0, 0, 100);
		send(OP_NOP, -1, 131071, 65535);
		send(OP_APPEND, 100, 40000, 0);
		send(OP_QUERY, 100, 0, 0);
		send(OP_QUERY, 99, 0, 0);
		send(OP_QUERY, 101, 0, 0);
		send(OP_APPEND, 100, 1, 0);
		send(OP_APPEND, 50, 1, 0);
		send(OP_APPEND, 25500, 131071, 0);
		send(OP_APPEND, -25500, 0, 0);
		send(OP_QUERY, 25500, 0, 0);
		send(OP_QUERY, 12000, 0, 0);
		send(OP_QUERY, 32767, 0, 0);
		send(OP_QUERY, -32768, 0, 0);
		send(OP_CLEAR, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0);
		for (int i = 0; i < MAX_POINTS + 1; i++)
			send(OP_APPEND, i * 100 - 25500, i * 2000, 0);
		write_ref_len(1);
		send(OP_QUERY, -25500, 0, 65535);
		send(OP_QUERY, -25450, 0, 0);
		send(OP_QUERY, -25450, 0, 3);
		write_ref_len(65535);
		send(OP_QUERY, -20000, 0, 1);
		send(OP_QUERY, -20000, 0, 65535);

		refs = '{0, 1, 65535, 0, 0};
		for (int ph = 0; ph < 32; ph++) begin
			idle_en = !(ph >= 12 && ph < 18);
			if (ph % 3 == 0)
				write_ref_len((ph / 3 < 3) ? refs[ph / 3] : ($urandom_range(2) == 0 ? 0
					: $urandom_range(1, 65535)));
			run_phase($urandom_range(34, 49));
		end

		req.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (600) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
